/* design/rsie_pkg.sv */
// ----------------------------------------------------------------------------
// rsie_pkg: shared types and constants
// Opcodes, error codes, payload structs, sequencer states and the sizes of the data memory.
// ----------------------------------------------------------------------------
package rsie_pkg;

  localparam int unsigned MemBytes = 32768;
  localparam int unsigned MemAw    = $clog2(MemBytes);

  typedef enum logic [5:0] {
    OP_LUI = 6'd0, OP_JAL = 6'd1, OP_JALR = 6'd2, OP_BEQ = 6'd3, OP_BNE = 6'd4,
    OP_BLT = 6'd5, OP_BGE = 6'd6, OP_BLTU = 6'd7, OP_BGEU = 6'd8, OP_BGT = 6'd9,
    OP_BLE = 6'd10, OP_BGTU = 6'd11, OP_BLEU = 6'd12, OP_LB = 6'd13, OP_LBU = 6'd14,
    OP_LH = 6'd15, OP_LHU = 6'd16, OP_LW = 6'd17, OP_SB = 6'd18, OP_SH = 6'd19,
    OP_SW = 6'd20, OP_ADDI = 6'd21, OP_SLTI = 6'd22, OP_SLTIU = 6'd23,
    OP_XORI = 6'd24, OP_ORI = 6'd25, OP_ANDI = 6'd26, OP_SLLI = 6'd27,
    OP_SRLI = 6'd28, OP_SRAI = 6'd29, OP_ADD = 6'd30, OP_SUB = 6'd31,
    OP_MUL = 6'd32, OP_DIV = 6'd33, OP_SLL = 6'd34, OP_SLT = 6'd35,
    OP_SLTU = 6'd36, OP_XOR = 6'd37, OP_SRL = 6'd38, OP_SRA = 6'd39,
    OP_OR = 6'd40, OP_AND = 6'd41, OP_LI = 6'd42, OP_MV = 6'd43, OP_NOT = 6'd44,
    OP_NEG = 6'd45, OP_J = 6'd46, OP_RET = 6'd47, OP_CALL = 6'd48, OP_JR = 6'd49,
    OP_BEQZ = 6'd50, OP_BNEZ = 6'd51, OP_BLTZ = 6'd52, OP_BGEZ = 6'd53,
    OP_BGTZ = 6'd54, OP_BLEZ = 6'd55, OP_ECALL = 6'd56, OP_BNEFT = 6'd57,
    OP_NOP = 6'd58
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_DIV = 2'd1, ERR_ADDR = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDA, ST_RDB, ST_EXEC, ST_MEM, ST_MEMW, ST_DIV, ST_DIVF, ST_DONE
  } state_e;

  typedef struct packed {
    logic [5:0]  cmd;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic signed [31:0] immediate;
    logic [15:0] jump_target;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  written_index;
    logic signed [31:0] written_value;
    logic        halted;
    logic [1:0]  error;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic        busy;
    logic        done;
  } div_stat_t;

endpackage

/* design/rsie_ram.sv */
// ----------------------------------------------------------------------------
// rsie_ram: generic single-port RAM
// One address per cycle, written and read together; registered read data.
// ----------------------------------------------------------------------------
module rsie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* design/rsie_div.sv */
// ----------------------------------------------------------------------------
// rsie_div: iterative signed divider
// Restoring divide, one quotient bit per cycle; flags a zero or inexact divide.
// ----------------------------------------------------------------------------
module rsie_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output rsie_pkg::div_stat_t stat_o,
  output logic [31:0] quot_o,
  output logic        bad_o
);
  import rsie_pkg::*;

  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d, zero_q, zero_d;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q; zero_d = zero_q;
    shifted = {rem_q[30:0], quo_q[31]};
    trial = {1'b0, shifted} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = a_i[31] ? (32'd0 - a_i) : a_i;
      den_d  = b_i[31] ? (32'd0 - b_i) : b_i;
      neg_d  = a_i[31] ^ b_i[31];
      zero_d = (b_i == 32'd0);
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d; zero_q <= zero_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = !busy_q && (cnt_q == 6'd0);
  assign quot_o = neg_q ? (32'd0 - quo_q) : quo_q;
  assign bad_o  = zero_q || (rem_q != 32'd0);
endmodule

/* design/rv32_subset_instruction_executor_unit.sv */
// ----------------------------------------------------------------------------
// rv32_subset_instruction_executor_unit: multi-cycle RV32 subset executor
// Executes one decoded instruction per item over a small sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  in      | in_valid_i, in_ready_o, in_i    | item in: one decoded instruction
//  out     | out_valid_o, out_ready_i, out_o | item out: pc, write-back, status
//
//  sequence: register ops go through read a, read b, execute and done;
//    loads and stores add a memory step per byte (up to 4 bytes, one ram
//    port), loads one more for the registered read; div waits on the
//    divider, one quotient bit per cycle
//  reset: after reset the 32768 bytes of data memory are swept to zero, one
//    byte a cycle, before the first item is taken; the register
//    file is set in the same sweep, sp to the memory size
//  stalls: the result waits in an output register; the next item is taken
//    the cycle after the result has gone
// ----------------------------------------------------------------------------
module rv32_subset_instruction_executor_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rsie_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsie_pkg::out_item_t out_o
);
  import rsie_pkg::*;

  state_e state_q, state_d;

  // register file: 32 words, read at one address a cycle from the sequencer
  logic        rf_we;
  logic [4:0]  rf_addr;
  logic [31:0] rf_wdata, rf_rdata;
  logic [31:0] pc_q, pc_d;
  logic        halt_q, halt_d;

  // data memory and clearing sweep
  logic             clr_q, clr_d;
  logic [MemAw-1:0] clr_cnt_q, clr_cnt_d;
  logic             dm_we;
  logic [MemAw-1:0] dm_addr;
  logic [7:0]       dm_wdata, dm_rdata;

  in_item_t    item_q, item_d;
  logic [31:0] va_q, va_d, vb_q, vb_d;
  logic [31:0] val_q, val_d;
  logic [31:0] npc_q, npc_d;
  logic        wr_q, wr_d;
  logic [4:0]  widx_q, widx_d;
  err_e        err_q, err_d;
  logic [2:0]  byte_q, byte_d;  // byte step of a memory access
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        div_start, div_bad;
  logic [31:0] div_quot;
  div_stat_t   div_stat;

  // combinational decode helpers
  logic [31:0] imm, addr;
  logic [4:0]  rb_idx;
  logic [32:0] addr_end;
  logic [2:0]  nbytes;
  logic        ts_lt, tu_lt, br;
  logic [4:0]  shamt;
  op_e         op;

  rsie_ram #(.Width(32), .Depth(32)) u_rf (
    .clk_i, .we_i(rf_we), .addr_i(rf_addr), .wdata_i(rf_wdata), .rdata_o(rf_rdata)
  );

  rsie_ram #(.Width(8), .Depth(MemBytes)) u_dm (
    .clk_i, .we_i(dm_we), .addr_i(dm_addr), .wdata_i(dm_wdata), .rdata_o(dm_rdata)
  );

  rsie_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(va_q), .b_i(vb_q),
    .stat_o(div_stat), .quot_o(div_quot), .bad_o(div_bad)
  );

  // second operand read: ra for ret, a0 for ecall, rs2 otherwise
  assign rb_idx   = (op == OP_RET) ? 5'd1 : (op == OP_ECALL) ? 5'd10 : item_q.src_reg_b;

  assign op       = op_e'(item_q.cmd);
  assign imm      = item_q.immediate;
  assign addr     = va_q + imm;
  assign addr_end = {1'b0, addr} + {30'd0, nbytes};
  assign shamt    = (op inside {OP_SLLI, OP_SRLI, OP_SRAI}) ? imm[4:0] : vb_q[4:0];

  always_comb begin
    case (op)
      OP_LB, OP_LBU, OP_SB: nbytes = 3'd1;
      OP_LH, OP_LHU, OP_SH: nbytes = 3'd2;
      default:              nbytes = 3'd4;
    endcase
  end

  always_comb begin
    state_d = state_q; item_d = item_q; va_d = va_q; vb_d = vb_q; val_d = val_q;
    npc_d = npc_q; wr_d = wr_q; widx_d = widx_q; err_d = err_q; byte_d = byte_q;
    pc_d = pc_q; halt_d = halt_q;
    out_valid_d = out_valid_q; out_d = out_q;
    clr_d = clr_q; clr_cnt_d = clr_cnt_q;
    rf_we = 1'b0; rf_addr = item_q.src_reg_a; rf_wdata = val_q;
    dm_we = 1'b0; dm_addr = addr[MemAw-1:0] + MemAw'(byte_q); dm_wdata = '0;
    div_start = 1'b0;
    ts_lt = 1'b0; tu_lt = 1'b0; br = 1'b0;
    in_ready_o = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (clr_q) begin
          dm_we = 1'b1; dm_addr = clr_cnt_q; dm_wdata = '0;
          // register file set in the same sweep, sp to the memory size
          rf_we = 1'b1; rf_addr = clr_cnt_q[4:0];
          rf_wdata = (clr_cnt_q[4:0] == 5'd2) ? 32'(MemBytes) : '0;
          clr_cnt_d = clr_cnt_q + MemAw'(1);
          if (clr_cnt_q == MemAw'(MemBytes - 1)) clr_d = 1'b0;
        end else begin
          in_ready_o = !out_valid_q;
          if (in_valid_i && !out_valid_q) begin
            item_d = in_i;
            rf_addr = in_i.src_reg_a;
            state_d = ST_RDA;
          end
        end
      end
      ST_RDA: begin
        va_d = (item_q.src_reg_a == 5'd0) ? '0 : rf_rdata;
        rf_addr = rb_idx;
        state_d = ST_RDB;
      end
      ST_RDB: begin
        vb_d = (rb_idx == 5'd0) ? '0 : rf_rdata;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        ts_lt = $signed(va_q) < $signed(vb_q);
        tu_lt = va_q < vb_q;
        wr_d = 1'b0; val_d = '0; err_d = ERR_NONE; widx_d = item_q.dest_reg;
        npc_d = pc_q + 32'd1; byte_d = '0;
        state_d = ST_DONE;
        if (halt_q) begin
          npc_d = pc_q;
        end else begin
          case (op)
            OP_LUI:  begin wr_d = 1'b1; val_d = {imm[19:0], 12'd0}; end
            OP_JAL:  begin wr_d = 1'b1; val_d = pc_q + 32'd1;
                       npc_d = {16'd0, item_q.jump_target}; end
            OP_JALR: begin wr_d = 1'b1; val_d = pc_q + 32'd1; npc_d = addr; end
            OP_BEQ:  br = va_q == vb_q;
            OP_BNE:  br = va_q != vb_q;
            OP_BLT:  br = ts_lt;
            OP_BGE:  br = !ts_lt;
            OP_BLTU: br = tu_lt;
            OP_BGEU: br = !tu_lt;
            OP_BGT:  br = $signed(vb_q) < $signed(va_q);
            OP_BLE:  br = !($signed(vb_q) < $signed(va_q));
            OP_BGTU: br = vb_q < va_q;
            OP_BLEU: br = !(vb_q < va_q);
            OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_SB, OP_SH, OP_SW: begin
              if (addr_end > 33'(MemBytes)) err_d = ERR_ADDR;
              else state_d = ST_MEM;
            end
            OP_ADDI:  begin wr_d = 1'b1; val_d = addr; end
            OP_SLTI:  begin wr_d = 1'b1; val_d = {31'd0, $signed(va_q) < $signed(imm)}; end
            OP_SLTIU: begin wr_d = 1'b1; val_d = {31'd0, va_q < imm}; end
            OP_XORI:  begin wr_d = 1'b1; val_d = va_q ^ imm; end
            OP_ORI:   begin wr_d = 1'b1; val_d = va_q | imm; end
            OP_ANDI:  begin wr_d = 1'b1; val_d = va_q & imm; end
            OP_SLLI, OP_SLL: begin wr_d = 1'b1; val_d = va_q << shamt; end
            OP_SRLI, OP_SRL: begin wr_d = 1'b1; val_d = va_q >> shamt; end
            OP_SRAI, OP_SRA: begin wr_d = 1'b1; val_d = 32'($signed(va_q) >>> shamt); end
            OP_ADD:  begin wr_d = 1'b1; val_d = va_q + vb_q; end
            OP_SUB:  begin wr_d = 1'b1; val_d = va_q - vb_q; end
            OP_MUL:  begin wr_d = 1'b1; val_d = va_q * vb_q; end
            OP_DIV:  begin div_start = 1'b1; state_d = ST_DIV; end
            OP_SLT:  begin wr_d = 1'b1; val_d = {31'd0, ts_lt}; end
            OP_SLTU: begin wr_d = 1'b1; val_d = {31'd0, tu_lt}; end
            OP_XOR:  begin wr_d = 1'b1; val_d = va_q ^ vb_q; end
            OP_OR:   begin wr_d = 1'b1; val_d = va_q | vb_q; end
            OP_AND:  begin wr_d = 1'b1; val_d = va_q & vb_q; end
            OP_LI:   begin wr_d = 1'b1; val_d = imm; end
            OP_MV:   begin wr_d = 1'b1; val_d = va_q; end
            OP_NOT:  begin wr_d = 1'b1; val_d = ~va_q; end
            OP_NEG:  begin wr_d = 1'b1; val_d = 32'd0 - va_q; end
            OP_J:    npc_d = {16'd0, item_q.jump_target};
            OP_RET:  npc_d = vb_q;
            OP_CALL: begin wr_d = 1'b1; widx_d = 5'd1; val_d = pc_q + 32'd1;
                       npc_d = {16'd0, item_q.jump_target}; end
            OP_JR:   npc_d = va_q;
            OP_BEQZ: br = va_q == 32'd0;
            OP_BNEZ: br = va_q != 32'd0;
            OP_BLTZ: br = va_q[31];
            OP_BGEZ: br = !va_q[31];
            OP_BGTZ: br = va_q != 32'd0 && !va_q[31];
            OP_BLEZ: br = va_q == 32'd0 || va_q[31];
            OP_ECALL: if (vb_q == 32'd10) begin halt_d = 1'b1; npc_d = pc_q; end
            OP_BNEFT: br = va_q != imm;
            default: ;
          endcase
          if (br) npc_d = {16'd0, item_q.jump_target};
        end
      end
      ST_MEM: begin
        // one byte per cycle; load data lands in the next cycle, from the registered read
        if (op inside {OP_SB, OP_SH, OP_SW}) begin
          dm_we = 1'b1;
          dm_wdata = vb_q[8*byte_q[1:0] +: 8];
          byte_d = byte_q + 3'd1;
          if (byte_q + 3'd1 == nbytes) state_d = ST_DONE;
        end else begin
          state_d = ST_MEMW;
        end
      end
      ST_MEMW: begin
        val_d[8*byte_q[1:0] +: 8] = dm_rdata;
        byte_d = byte_q + 3'd1;
        if (byte_q + 3'd1 == nbytes) begin
          wr_d = 1'b1;
          if (op == OP_LH) val_d = {{16{dm_rdata[7]}}, dm_rdata, val_q[7:0]};
          if (op == OP_LB) val_d = {{24{dm_rdata[7]}}, dm_rdata};
          state_d = ST_DONE;
        end else begin
          dm_addr = addr[MemAw-1:0] + MemAw'(byte_q + 3'd1);
          state_d = ST_MEMW;
        end
      end
      ST_DIV: state_d = ST_DIVF;
      ST_DIVF: begin
        if (div_stat.done) begin
          if (div_bad) err_d = ERR_DIV;
          else begin wr_d = 1'b1; val_d = div_quot; end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (wr_q && widx_q != 5'd0) begin
          rf_we = 1'b1; rf_addr = widx_q; rf_wdata = val_q;
        end
        pc_d = npc_q;
        out_d.next_pc       = npc_q;
        out_d.reg_written   = wr_q && widx_q != 5'd0;
        out_d.written_index = (wr_q && widx_q != 5'd0) ? widx_q : 5'd0;
        out_d.written_value = (wr_q && widx_q != 5'd0) ? val_q : 32'd0;
        out_d.halted        = halt_q;
        out_d.error         = err_q;
        out_valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      halt_q      <= halt_d;
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, loaded before use
  always_ff @(posedge clk_i) begin
    item_q <= item_d; va_q <= va_d; vb_q <= vb_d; val_q <= val_d; npc_q <= npc_d;
    wr_q <= wr_d; widx_q <= widx_d; err_q <= err_d; byte_q <= byte_d; out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // no item is taken while the result register is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("item taken over pending result");

  // no item is taken during the memory sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_ready_o) else $error("item taken during memory clear");

  // once halted the pc is frozen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> $stable(pc_q)) else $error("pc moved after halt");
endmodule
